// File: rtl/m6502_split_pkg.sv
// Package for the 6502 instruction splitter: beat types, phase and mode codes,
// and the opcode to addressing-mode table. No dependencies.
package m6502_split_pkg;

  // Input beat: one byte of the program image
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Output beat: one instruction record
  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode;
    logic [3:0]  addr_mode;
    logic [15:0] operand;
    logic [1:0]  instr_length;
    logic [15:0] branch_target;
    logic        unnamed_opcode;
    logic        truncated;
  } out_beat_t;

  typedef enum logic [2:0] {
    PH_HDR_LO = 3'd0,
    PH_HDR_HI = 3'd1,
    PH_OPCODE = 3'd2,
    PH_OPND1  = 3'd3,
    PH_OPND2  = 3'd4
  } phase_t;

  localparam logic [3:0] MODE_IMPLIED = 4'd0;
  localparam logic [3:0] MODE_REL     = 4'd7;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // Addressing mode per opcode; DOP, TOP and ANC read as implied
  localparam logic [3:0] MODE_TABLE [0:255] = '{
    0,5,0,5,0,2,2,2,0,1,0,0,0,8,8,8,
    7,6,0,6,0,3,3,3,0,10,0,10,0,9,9,9,
    8,5,0,5,2,2,2,2,0,1,0,0,8,8,8,8,
    7,6,0,6,0,3,3,3,0,10,0,10,0,9,9,9,
    0,5,0,5,0,2,2,2,0,1,0,1,8,8,8,8,
    7,6,0,6,0,3,3,3,0,10,0,10,0,9,9,9,
    0,5,0,5,0,2,2,2,0,1,0,1,11,8,8,8,
    7,6,0,6,0,3,3,3,0,10,0,10,0,9,9,9,
    0,5,0,5,2,2,2,2,0,0,0,0,8,8,8,8,
    7,6,0,0,3,3,4,4,0,10,0,0,0,9,10,0,
    1,5,1,5,2,2,2,2,0,1,0,0,8,8,8,8,
    7,6,0,6,3,3,4,4,0,10,0,0,9,9,10,10,
    1,5,0,5,2,2,2,2,0,1,0,1,8,8,8,8,
    7,6,0,6,0,3,3,3,0,10,0,10,0,9,9,9,
    1,5,0,5,2,2,2,2,0,1,0,0,8,8,8,8,
    7,6,0,6,0,3,3,3,0,10,0,10,0,9,9,9
  };

  // Instruction length in bytes for a mode
  function automatic logic [1:0] mode_length(input logic [3:0] mode);
    logic [1:0] len;
    if (mode == MODE_IMPLIED) begin
      len = LEN_ONE;
    end else if (mode <= MODE_REL) begin
      len = LEN_TWO;
    end else begin
      len = LEN_THREE;
    end
    return len;
  endfunction

  // Opcodes with no mnemonic
  function automatic logic is_unnamed(input logic [7:0] op);
    return (op == 8'h8B) || (op == 8'h93) || (op == 8'h9B) || (op == 8'h9C) ||
           (op == 8'h9F) || (op == 8'hAB) || (op == 8'hBB);
  endfunction

endpackage

// File: rtl/mos6502_instruction_splitter_core.sv
// 6502 instruction splitter: turns a byte stream (load address header, then code)
// into one record per instruction. Depends on m6502_split_pkg.
// A record is built from its final byte in the input register and is then held
// in the result register. Throughput: one byte per cycle; the input
// stalls only while a record waits in the result register and another is due.
// Reset (synchronous) returns to the header low byte phase with both stages empty.
module mos6502_instruction_splitter_core
  import m6502_split_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  // Input register
  logic     held_valid;
  in_beat_t held_beat;

  // Decode state
  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] running_address;
  logic [15:0] running_address_next;
  logic [7:0]  header_low;
  logic [7:0]  held_opcode;
  logic [7:0]  operand_low;

  // Decode of the held byte
  logic        emit;
  logic        advance;
  logic [7:0]  rec_op;
  logic [3:0]  rec_mode;
  logic [1:0]  rec_len;
  logic [15:0] rec_operand;
  logic        rec_trunc;
  logic [15:0] rec_target;
  out_beat_t   rec;

  logic [7:0] b;
  logic       last;

  assign b    = held_beat.data_byte;
  assign last = held_beat.last_byte;

  // Opcode comes from the held byte in opcode phase, else from the saved one
  assign rec_op   = (phase == PH_OPCODE) ? b : held_opcode;
  assign rec_mode = MODE_TABLE[rec_op];
  assign rec_len  = mode_length(rec_mode);

  // Next state and record contents
  always_comb begin
    phase_next           = phase;
    running_address_next = running_address;
    emit                 = 1'b0;
    rec_operand          = 16'h0000;
    rec_trunc            = 1'b0;
    unique case (phase)
      PH_HDR_HI: begin
        running_address_next = {b, header_low};
        phase_next           = last ? PH_HDR_LO : PH_OPCODE;
      end
      PH_OPCODE: begin
        if (rec_len == LEN_ONE) begin
          emit = 1'b1;
        end else if (last) begin
          emit      = 1'b1;
          rec_trunc = 1'b1;
        end else begin
          phase_next = PH_OPND1;
        end
      end
      PH_OPND1: begin
        rec_operand = {8'h00, b};
        if (rec_len == LEN_TWO) begin
          emit = 1'b1;
        end else if (last) begin
          emit      = 1'b1;
          rec_trunc = 1'b1;
        end else begin
          phase_next = PH_OPND2;
        end
      end
      PH_OPND2: begin
        rec_operand = {b, operand_low};
        emit        = 1'b1;
      end
      default: begin
        phase_next = last ? PH_HDR_LO : PH_HDR_HI;
      end
    endcase
    if (emit) begin
      running_address_next = running_address + {14'd0, rec_len};
      phase_next           = last ? PH_HDR_LO : PH_OPCODE;
    end
  end

  // Branch target: address + 2 + sign-extended offset
  assign rec_target = (rec_mode == MODE_REL) ?
      running_address + 16'd2 + {{8{rec_operand[7]}}, rec_operand[7:0]} : 16'h0000;

  always_comb begin
    rec.instr_address  = running_address;
    rec.opcode         = rec_op;
    rec.addr_mode      = rec_mode;
    rec.operand        = rec_operand;
    rec.instr_length   = rec_len;
    rec.branch_target  = rec_target;
    rec.unnamed_opcode = is_unnamed(rec_op);
    rec.truncated      = rec_trunc;
  end

  // Advance the held byte unless its record would overwrite one still waiting
  assign advance  = held_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  // Hold the incoming beat
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat <= in_data;
    end
  end

  // Advance decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR_LO;
      running_address <= 16'h0000;
    end else if (advance) begin
      phase           <= phase_next;
      running_address <= running_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (phase != PH_HDR_HI && phase != PH_OPCODE && phase != PH_OPND1 &&
          phase != PH_OPND2) begin
        header_low <= b;
      end
      if (phase == PH_OPCODE) begin
        held_opcode <= b;
      end
      if (phase == PH_OPND1) begin
        operand_low <= b;
      end
    end
  end

  // Result register: load a new record, drop a taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= rec;
    end
  end

endmodule
